// ===== rtl/tfn_pkg.sv =====
// Package: widths, stage counts and shared types of the triangle face normal pipeline.
`timescale 1ns / 1ps
package tfn_pkg;
  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int EDGE_W    = COORD_BITS + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int RED_BITS  = 30;
  localparam int SQ_W      = 2 * RED_BITS;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int RT_W      = SUM_W + 1;
  localparam int LEN_W     = ROOT_STEPS;
  localparam int Q_W       = NORMAL_FRAC_BITS + 1;
  localparam int OUT_W     = NORMAL_FRAC_BITS + 2;
  localparam int REM_W     = RED_BITS + NORMAL_FRAC_BITS + 2;
  localparam int CHUNK_W   = 10;
  localparam int CHUNKS    = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int CPOS_W    = $clog2(CHUNK_W + 1);
  localparam int BLEN_W    = $clog2(MAG_W + 1);
  localparam int IN_W      = 9 * COORD_BITS;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic [2:0][RED_BITS-1:0] m;
    logic [2:0]               neg;
    logic                     degen;
  } side_t;
endpackage

// ===== rtl/triangle_face_normal_top.sv =====
// Top level: pipelined unit face normal of one triangle per transfer.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_axis_*: one triangle per transfer, nine signed Q12.12
//   coordinates packed in s_axis_tdata (first x,y,z, second x,y,z, third x,y,z).
//   Output channel m_axis_*: one unit normal per triangle in signed Q2.14
//   (x, y, z in m_axis_tdata), m_axis_tuser set for a degenerate triangle,
//   whose normal is then zero.
//   One triangle enters every cycle while the output is not stalled. The
//   pipeline depth comes from the square root (one result bit per stage,
//   31 stages) and the three dividers (one quotient bit per stage, 15 stages),
//   plus edge, product, cross, magnitude, two leading-one search, shift,
//   square, sum and division setup stages and the output stage.
//   Reset clears all stage valid bits; the pipeline is empty afterwards.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline holds and s_axis_tready drops; nothing is lost or repeated.
module triangle_face_normal_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  logic [tfn_pkg::IN_BYTES_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [tfn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // degenerate
  output logic                           m_axis_tuser
);
  localparam int CB  = tfn_pkg::COORD_BITS;
  localparam int EW  = tfn_pkg::EDGE_W;
  localparam int RS  = tfn_pkg::ROOT_STEPS;
  localparam int QW  = tfn_pkg::Q_W;
  localparam int LAT = 9 + RS + 1 + QW + 1;

  logic           ce;
  logic [LAT-1:0] v;

  assign ce            = !v[LAT-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = v[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[LAT-2:0], s_axis_tvalid};
    end
  end

  // edges
  logic signed [CB-1:0]    pc [0:8];
  logic signed [2:0][EW-1:0] e1, e2;
  always_comb begin
    for (int i = 0; i < 9; i++) pc[i] = s_axis_tdata[i*CB +: CB];
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(pc[i]) - EW'(pc[i+3]);
        e2[i] <= EW'(pc[i+3]) - EW'(pc[i+6]);
      end
    end
  end

  // products
  logic signed [tfn_pkg::PROD_W-1:0] pr [0:5];
  always_ff @(posedge clk) begin
    if (ce) begin
      pr[0] <= $signed(e1[1]) * $signed(e2[2]);
      pr[1] <= $signed(e1[2]) * $signed(e2[1]);
      pr[2] <= $signed(e1[2]) * $signed(e2[0]);
      pr[3] <= $signed(e1[0]) * $signed(e2[2]);
      pr[4] <= $signed(e1[0]) * $signed(e2[1]);
      pr[5] <= $signed(e1[1]) * $signed(e2[0]);
    end
  end

  // cross product
  logic signed [tfn_pkg::CROSS_W-1:0] cr [0:2];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++)
        cr[i] <= tfn_pkg::CROSS_W'(pr[2*i]) - tfn_pkg::CROSS_W'(pr[2*i+1]);
    end
  end

  // magnitudes
  logic [tfn_pkg::MAG_W-1:0] mg [0:2];
  logic [tfn_pkg::MAG_W-1:0] mor;
  logic [2:0]                ng4;
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ng4[i] <= cr[i][tfn_pkg::CROSS_W-1];
        mg[i]  <= tfn_pkg::MAG_W'(cr[i][tfn_pkg::CROSS_W-1] ? -cr[i] : cr[i]);
      end
      mor <= tfn_pkg::MAG_W'(cr[0][tfn_pkg::CROSS_W-1] ? -cr[0] : cr[0])
           | tfn_pkg::MAG_W'(cr[1][tfn_pkg::CROSS_W-1] ? -cr[1] : cr[1])
           | tfn_pkg::MAG_W'(cr[2][tfn_pkg::CROSS_W-1] ? -cr[2] : cr[2]);
    end
  end

  // leading-one search, per chunk
  logic [tfn_pkg::CPOS_W-1:0] cpos_next [0:tfn_pkg::CHUNKS-1];
  logic [tfn_pkg::CPOS_W-1:0] cpos      [0:tfn_pkg::CHUNKS-1];
  logic [tfn_pkg::MAG_W-1:0]  mg5 [0:2];
  logic [2:0]                 ng5;
  always_comb begin
    for (int c = 0; c < tfn_pkg::CHUNKS; c++) begin
      cpos_next[c] = '0;
      for (int b = 0; b < tfn_pkg::CHUNK_W; b++) begin
        if (c * tfn_pkg::CHUNK_W + b < tfn_pkg::MAG_W) begin
          if (mor[c * tfn_pkg::CHUNK_W + b]) cpos_next[c] = tfn_pkg::CPOS_W'(b + 1);
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      cpos <= cpos_next;
      mg5  <= mg;
      ng5  <= ng4;
    end
  end

  // bit length of the largest magnitude
  logic [tfn_pkg::BLEN_W-1:0] blen_next, blen;
  logic [tfn_pkg::MAG_W-1:0]  mg6 [0:2];
  logic [2:0]                 ng6;
  always_comb begin
    blen_next = '0;
    for (int c = 0; c < tfn_pkg::CHUNKS; c++) begin
      if (cpos[c] != '0)
        blen_next = tfn_pkg::BLEN_W'(c * tfn_pkg::CHUNK_W) + tfn_pkg::BLEN_W'(cpos[c]);
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      blen <= blen_next;
      mg6  <= mg5;
      ng6  <= ng5;
    end
  end

  // scale to RED_BITS
  tfn_pkg::side_t sd [0:RS+2];
  tfn_pkg::side_t sd_next;
  always_comb begin
    sd_next.neg   = ng6;
    sd_next.degen = (blen == '0);
    for (int i = 0; i < 3; i++) begin
      if (blen > tfn_pkg::BLEN_W'(tfn_pkg::RED_BITS))
        sd_next.m[i] = tfn_pkg::RED_BITS'(mg6[i] >> (blen - tfn_pkg::BLEN_W'(tfn_pkg::RED_BITS)));
      else
        sd_next.m[i] = tfn_pkg::RED_BITS'(mg6[i] << (tfn_pkg::BLEN_W'(tfn_pkg::RED_BITS) - blen));
    end
  end

  // squares and sum
  logic [tfn_pkg::SQ_W-1:0] sq [0:2];
  always_ff @(posedge clk) begin
    if (ce) begin
      sd[0] <= sd_next;
      for (int k = 1; k <= RS + 2; k++) sd[k] <= sd[k-1];
      for (int i = 0; i < 3; i++) sq[i] <= sd[0].m[i] * sd[0].m[i];
    end
  end

  // square root, one result bit per stage
  logic [tfn_pkg::RT_W-1:0] rem [0:RS];
  logic [tfn_pkg::RT_W-1:0] res [0:RS];
  logic [tfn_pkg::RT_W-1:0] rem_next [0:RS-1];
  logic [tfn_pkg::RT_W-1:0] res_next [0:RS-1];
  always_comb begin
    logic [tfn_pkg::RT_W-1:0] bt, cand;
    for (int k = 0; k < RS; k++) begin
      bt   = tfn_pkg::RT_W'(1) << (2 * (RS - 1 - k));
      cand = res[k] + bt;
      if (rem[k] >= cand) begin
        rem_next[k] = rem[k] - cand;
        res_next[k] = (res[k] >> 1) + bt;
      end else begin
        rem_next[k] = rem[k];
        res_next[k] = res[k] >> 1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= tfn_pkg::RT_W'(sq[0]) + tfn_pkg::RT_W'(sq[1]) + tfn_pkg::RT_W'(sq[2]);
      res[0] <= '0;
      for (int k = 0; k < RS; k++) begin
        rem[k+1]  <= rem_next[k];
        res[k+1]  <= res_next[k];
      end
    end
  end

  // division setup
  logic [tfn_pkg::LEN_W-1:0] root_len;
  logic [tfn_pkg::LEN_W-1:0] dlen [0:QW];
  logic [tfn_pkg::REM_W-1:0] drem [0:QW][0:2];
  logic [QW-1:0]             dq   [0:QW][0:2];
  logic [2:0]                dng  [0:QW];
  logic                      ddg  [0:QW];
  assign root_len = (res[RS][tfn_pkg::LEN_W-1:0] == '0) ? tfn_pkg::LEN_W'(1)
                                                        : res[RS][tfn_pkg::LEN_W-1:0];

  // restoring dividers, one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [tfn_pkg::REM_W-1:0] tr;
    if (ce) begin
      dlen[0] <= root_len;
      dng[0]  <= sd[RS+2].neg;
      ddg[0]  <= sd[RS+2].degen;
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (tfn_pkg::REM_W'(sd[RS+2].m[i]) << tfn_pkg::NORMAL_FRAC_BITS)
                    + tfn_pkg::REM_W'(root_len >> 1);
        dq[0][i]   <= '0;
      end
      for (int d = 0; d < QW; d++) begin
        tr = tfn_pkg::REM_W'(dlen[d]) << (QW - 1 - d);
        dlen[d+1] <= dlen[d];
        dng[d+1]  <= dng[d];
        ddg[d+1]  <= ddg[d];
        for (int i = 0; i < 3; i++) begin
          if (drem[d][i] >= tr) begin
            drem[d+1][i] <= drem[d][i] - tr;
            dq[d+1][i]   <= {dq[d][i][QW-2:0], 1'b1};
          end else begin
            drem[d+1][i] <= drem[d][i];
            dq[d+1][i]   <= {dq[d][i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // output register
  logic [2:0][tfn_pkg::OUT_W-1:0] nrm;
  logic                           dgo;
  always_ff @(posedge clk) begin
    if (ce) begin
      dgo <= ddg[QW];
      for (int i = 0; i < 3; i++)
        nrm[i] <= dng[QW][i] ? -tfn_pkg::OUT_W'(dq[QW][i]) : tfn_pkg::OUT_W'(dq[QW][i]);
    end
  end

  assign m_axis_tdata = tfn_pkg::OUT_DATA_W'(nrm);
  assign m_axis_tuser = dgo;
endmodule

// ===== rtl/tfn_checker.sv =====
// Checker: port-level properties of the face normal pipeline, bound to the top level.
`timescale 1ns / 1ps
module tfn_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tfn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  localparam int OW = tfn_pkg::OUT_W;

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero normal");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked with free output");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[OW-1:0]) >= -(2 ** tfn_pkg::NORMAL_FRAC_BITS)
                   && $signed(m_axis_tdata[OW-1:0]) <= (2 ** tfn_pkg::NORMAL_FRAC_BITS))
    else $error("normal x out of range");
endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb_triangle_face_normal_top.sv =====
// Testbench: random and directed triangles against a bit-exact face normal predictor.
`timescale 1ns / 1ps
module tb_triangle_face_normal_top;
  localparam int COORD_BITS       = tfn_pkg::COORD_BITS;
  localparam int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS;
  localparam int RED_BITS         = tfn_pkg::RED_BITS;
  localparam int OUT_W            = tfn_pkg::OUT_W;
  localparam int IN_BYTES_W       = tfn_pkg::IN_BYTES_W;
  localparam int OUT_DATA_W       = tfn_pkg::OUT_DATA_W;

  typedef struct packed {
    logic [OUT_W-1:0] nx;
    logic [OUT_W-1:0] ny;
    logic [OUT_W-1:0] nz;
    logic             degen;
  } normal_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_BYTES_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  logic [IN_BYTES_W-1:0] triangle_q[$];
  normal_t               normal_q[$];
  int                    errors = 0;
  int                    accepted = 0;
  int                    total_items = 0;
  bit                    loaded = 0;
  int                    send_idle_pct = 30;
  int                    recv_idle_pct = 56;

  triangle_face_normal_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(logic [IN_BYTES_W-1:0] d);
    longint p[9];
    longint c[3];
    longint mag[3];
    bit neg[3];
    longint unsigned m[3];
    longint unsigned sq, len, q;
    int maxlen, bl, sh;
    normal_t r;
    for (int i = 0; i < 9; i++) p[i] = $signed(d[i*COORD_BITS +: COORD_BITS]);
    c[0] = (p[1] - p[4]) * (p[5] - p[8]) - (p[2] - p[5]) * (p[4] - p[7]);
    c[1] = (p[2] - p[5]) * (p[3] - p[6]) - (p[0] - p[3]) * (p[5] - p[8]);
    c[2] = (p[0] - p[3]) * (p[4] - p[7]) - (p[1] - p[4]) * (p[3] - p[6]);
    maxlen = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? -c[i] : c[i];
      bl = 0;
      while ((mag[i] >> bl) != 0) bl++;
      if (bl > maxlen) maxlen = bl;
    end
    r = '0;
    if (maxlen == 0) begin
      r.degen = 1'b1;
      return r;
    end
    sh = maxlen - RED_BITS;
    for (int i = 0; i < 3; i++)
      m[i] = (sh > 0) ? (mag[i] >> sh) : (mag[i] << (-sh));
    sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sq);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
      if (neg[i]) q = -q;
      if (i == 0) r.nx = q[OUT_W-1:0];
      else if (i == 1) r.ny = q[OUT_W-1:0];
      else r.nz = q[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [IN_BYTES_W-1:0] pack_corners(logic [COORD_BITS-1:0] c[9]);
    logic [IN_BYTES_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*COORD_BITS +: COORD_BITS] = c[i];
    return d;
  endfunction

  task automatic add_triangle(logic [COORD_BITS-1:0] c[9]);
    triangle_q = {triangle_q, pack_corners(c)};
    total_items++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (triangle_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= triangle_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    normal_t got, want;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      normal_q = {normal_q, face_normal(s_axis_tdata)};
      accepted++;
      if (accepted == total_items / 3) begin
        send_idle_pct <= 56;
        recv_idle_pct <= 30;
      end else if (accepted == (2 * total_items) / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[OUT_W-1:0], m_axis_tdata[2*OUT_W-1:OUT_W],
             m_axis_tdata[3*OUT_W-1:2*OUT_W], m_axis_tuser};
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected normal, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = normal_q.pop_front();
        if (got.nx !== want.nx) begin
          $display("%0t: normal_x expected %h actual %h", $time, want.nx, got.nx);
          errors++;
        end
        if (got.ny !== want.ny) begin
          $display("%0t: normal_y expected %h actual %h", $time, want.ny, got.ny);
          errors++;
        end
        if (got.nz !== want.nz) begin
          $display("%0t: normal_z expected %h actual %h", $time, want.nz, got.nz);
          errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degen, got.degen);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [COORD_BITS-1:0] c[9];
    logic [COORD_BITS-1:0] mx, mn;
    int kind, rng;
    mx = {1'b0, {(COORD_BITS-1){1'b1}}};
    mn = {1'b1, {(COORD_BITS-1){1'b0}}};
    // repeated corners: all zero, all maximum, all minimum
    c = '{default: '0};
    add_triangle(c);
    c = '{default: mx};
    add_triangle(c);
    c = '{default: mn};
    add_triangle(c);
    // unit axis triangles, both windings
    c = '{24'h001000, 0, 0, 0, 0, 0, 0, 24'h001000, 0};
    add_triangle(c);
    c = '{0, 24'h001000, 0, 0, 0, 0, 24'h001000, 0, 0};
    add_triangle(c);
    c = '{0, 0, 24'h001000, 0, 0, 0, 24'h001000, 0, 0};
    add_triangle(c);
    // collinear corners
    c = '{24'h000100, 24'h000200, 24'h000300, 24'h000200, 24'h000400, 24'h000600,
          24'h000300, 24'h000600, 24'h000900};
    add_triangle(c);
    // full range extremes
    c = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
    add_triangle(c);
    c = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
    add_triangle(c);
    c = '{mx, mx, mx, mn, mn, mn, mx, mn, mx};
    add_triangle(c);
    c = '{mn, mn, 0, mx, mn, 0, mx, mx, 0};
    add_triangle(c);
    c = '{mx, 0, mn, 0, mx, 0, mn, mn, mx};
    add_triangle(c);
    // tiny triangles, cross product components of one or two lsb
    c = '{1, 0, 0, 0, 0, 0, 0, 24'hffffff, 0};
    add_triangle(c);
    c = '{0, 0, 0, 1, 0, 0, 1, 1, 0};
    add_triangle(c);
    c = '{24'hffffff, 24'hffffff, 24'hffffff, 0, 0, 0, 1, 2, 3};
    add_triangle(c);
    for (int n = 0; n < 1650; n++) begin
      kind = $urandom_range(9);
      rng = (kind < 4) ? (1 << $urandom_range(20)) : 0;
      for (int i = 0; i < 9; i++) begin
        if (kind < 4) c[i] = COORD_BITS'($urandom_range(2 * rng) - rng);
        else c[i] = COORD_BITS'($urandom());
      end
      if (kind == 8) for (int i = 0; i < 3; i++) c[3 + $urandom_range(1) * 3 + i] = c[i];
      if (kind == 9) for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i] + (c[3 + i] - c[i]);
      add_triangle(c);
    end
    loaded = 1;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (loaded);
    while (triangle_q.size() != 0 || s_axis_tvalid || normal_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("PASS triangle_face_normal_top");
    else $display("FAIL triangle_face_normal_top");
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL triangle_face_normal_top");
    $finish;
  end
endmodule
